[src/lrt_pkg.sv]
// shared types, constants and helpers for the resident model tracker
`timescale 1ns / 1ps
`default_nettype none
package lrt_pkg;

	localparam int MAX_MODELS   = 16;
	localparam int MAX_RESIDENT = 8;

	localparam int IDX_W  = 4;
	localparam int MC_W   = 5;
	localparam int LIM_W  = 4;
	localparam int OCC_W  = 4;
	localparam int SLOT_W = $clog2(MAX_RESIDENT);
	localparam int ST_W   = 2;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [ST_W-1:0] ST_HIT     = 2'd0;
	localparam logic [ST_W-1:0] ST_LOADED  = 2'd1;
	localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;
	localparam logic [ST_W-1:0] ST_FAILED  = 2'd3;

	localparam logic REG_MODEL_COUNT    = 1'b0;
	localparam logic REG_RESIDENT_LIMIT = 1'b1;

	localparam logic [MC_W-1:0]  MC_RESET  = MC_W'(1);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1);

	typedef struct packed {
		logic             commit;
		logic [IDX_W-1:0] key;
	} lrt_cell_ctrl_t;

	function automatic logic [OCC_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
		logic [OCC_W-1:0] res;
		if (lim == '0) begin
			res = OCC_W'(1);
		end else if ({1'b0, lim} > (LIM_W+1)'(MAX_RESIDENT)) begin
			res = OCC_W'(MAX_RESIDENT);
		end else begin
			res = OCC_W'(lim);
		end
		return res;
	endfunction

	function automatic logic [MC_W-1:0] eff_models(input logic [MC_W-1:0] mc);
		logic [MC_W-1:0] res;
		if ({1'b0, mc} > (MC_W+1)'(MAX_MODELS)) begin
			res = MC_W'(MAX_MODELS);
		end else begin
			res = mc;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[src/lrt_cell.sv]
// one recency slot: holds a model index, compares it and shifts from its neighbour
`timescale 1ns / 1ps
`default_nettype none
module lrt_cell
	import lrt_pkg::*;
(
	input  wire logic             clk,
	input  wire lrt_cell_ctrl_t   ctrl,
	input  wire logic             slot_valid,
	input  wire logic             shift_ok,
	input  wire logic             go_in,
	input  wire logic [IDX_W-1:0] prev_value,
	output logic                  go_out,
	output logic                  match,
	output logic                  is_zero,
	output logic [IDX_W-1:0]      value
);

	logic [IDX_W-1:0] value_q;

	assign match   = slot_valid && (value_q == ctrl.key);
	assign is_zero = (value_q == '0);
	assign go_out  = go_in && !match;
	assign value   = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.commit && go_in && shift_ok) begin
			value_q <= prev_value;
		end
	end

endmodule
`default_nettype wire

[src/lru_resident_model_tracker_top.sv]
// resident model tracker top level: control, configuration registers and cell row
// the input transfer loads the request registers; the result enters the output register once it is free
// one request at a time: the next one is accepted only after the match-and-shift step of the cell row
// the output register lets a new request enter while a result waits
// reset: model_count 1, resident_limit 1, occupancy 0; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module lru_resident_model_tracker_top
	import lrt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [IDX_W-1:0]  model_index,
	input  wire logic              init_ok,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ST_W-1:0]        status,
	output logic                   evicted,
	output logic [IDX_W-1:0]       evicted_index,
	output logic [OCC_W-1:0]       resident_count,
	output logic                   default_resident
);

	localparam logic FSM_IDLE = 1'b0;
	localparam logic FSM_CALC = 1'b1;

	logic              state_q;
	logic [MC_W-1:0]   model_count_q;
	logic [LIM_W-1:0]  resident_limit_q;
	logic [OCC_W-1:0]  occ_q;
	logic [IDX_W-1:0]  idx_q;
	logic              ok_q;

	logic              out_valid_q;
	logic [ST_W-1:0]   status_q;
	logic              evicted_q;
	logic [IDX_W-1:0]  evicted_index_q;
	logic [OCC_W-1:0]  resident_count_q;
	logic              default_resident_q;

	logic              cfg_wr;
	logic              fire;
	logic              known;
	logic              hit;
	logic              full;
	logic              evict;
	logic              load;
	logic [OCC_W-1:0]  lim_eff;
	logic [OCC_W-1:0]  occ_keep;
	logic [OCC_W-1:0]  occ_next;
	logic [OCC_W-1:0]  shift_lim;
	logic [ST_W-1:0]   status_d;
	logic              zero_keep;
	logic [IDX_W-1:0]  ev_value;
	lrt_cell_ctrl_t    cell_ctrl;

	logic [IDX_W-1:0]        val [MAX_RESIDENT];
	logic [MAX_RESIDENT:0]   go;
	logic [MAX_RESIDENT-1:0] match_v;
	logic [MAX_RESIDENT-1:0] zero_v;
	logic [MAX_RESIDENT-1:0] zero_kept_v;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_MODEL_COUNT:    prdata = DATA_W'(model_count_q);
			REG_RESIDENT_LIMIT: prdata = DATA_W'(resident_limit_q);
			default:            prdata = '0;
		endcase
	end

	// request decode
	assign lim_eff   = eff_limit(resident_limit_q);
	assign known     = {1'b0, idx_q} < eff_models(model_count_q);
	assign hit       = |match_v;
	assign full      = (occ_q >= lim_eff) && (occ_q != '0);
	assign evict     = known && !hit && full;
	assign load      = known && !hit && ok_q;
	assign occ_keep  = evict ? occ_q - OCC_W'(1) : occ_q;
	assign occ_next  = load ? occ_keep + OCC_W'(1) : occ_keep;
	assign shift_lim = hit ? occ_q : occ_keep;
	assign ev_value  = val[SLOT_W'(occ_q - OCC_W'(1))];
	assign zero_keep = |zero_kept_v;

	assign fire             = (state_q == FSM_CALC) && (!out_valid_q || out_ready);
	assign cell_ctrl.commit = fire && known && (hit || ok_q);
	assign cell_ctrl.key    = idx_q;
	assign go[0]            = 1'b1;

	always_comb begin
		priority if (!known) begin
			status_d = ST_UNKNOWN;
		end else if (hit) begin
			status_d = ST_HIT;
		end else if (ok_q) begin
			status_d = ST_LOADED;
		end else begin
			status_d = ST_FAILED;
		end
	end

	// row of cells, slot 0 most recent
	for (genvar i = 0; i < MAX_RESIDENT; i++) begin : g_cell
		logic [IDX_W-1:0] prev;
		if (i == 0) begin : g_head
			assign prev = idx_q;
		end else begin : g_link
			assign prev = val[i-1];
		end
		assign zero_kept_v[i] = zero_v[i] && (OCC_W'(i) < occ_keep);
		lrt_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.slot_valid (OCC_W'(i) < occ_q),
			.shift_ok   (OCC_W'(i) <= shift_lim),
			.go_in      (go[i]),
			.prev_value (prev),
			.go_out     (go[i+1]),
			.match      (match_v[i]),
			.is_zero    (zero_v[i]),
			.value      (val[i])
		);
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= FSM_IDLE;
			model_count_q    <= MC_RESET;
			resident_limit_q <= LIM_RESET;
			occ_q            <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr && paddr[2] == REG_MODEL_COUNT) begin
				model_count_q <= pwdata[MC_W-1:0];
			end
			if (cfg_wr && paddr[2] == REG_RESIDENT_LIMIT) begin
				resident_limit_q <= pwdata[LIM_W-1:0];
				if (occ_q > eff_limit(pwdata[LIM_W-1:0])) begin
					occ_q <= eff_limit(pwdata[LIM_W-1:0]);
				end
			end
			unique case (state_q)
				FSM_IDLE: begin
					if (in_valid) begin
						state_q <= FSM_CALC;
					end
				end
				FSM_CALC: begin
					if (fire) begin
						state_q <= FSM_IDLE;
						occ_q   <= occ_next;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			idx_q <= model_index;
			ok_q  <= init_ok;
		end
		if (fire) begin
			status_q           <= status_d;
			evicted_q          <= evict;
			evicted_index_q    <= evict ? ev_value : '0;
			resident_count_q   <= occ_next;
			default_resident_q <= zero_keep || (load && idx_q == '0);
		end
	end

	assign in_ready         = (state_q == FSM_IDLE);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign evicted          = evicted_q;
	assign evicted_index    = evicted_index_q;
	assign resident_count   = resident_count_q;
	assign default_resident = default_resident_q;

endmodule
`default_nettype wire
